@@ rtl/core/mpjs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpjs_pkg: shared types and constants of the job scheduler
// Commands, policies, status codes, job record and controller interface.
// ----------------------------------------------------------------------------
package mpjs_pkg;

	localparam int QueueDepthDefault = 16;

	typedef enum logic [1:0] {
		CMD_NEW    = 2'd0,
		CMD_EXPIRE = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic [2:0] POL_FCFS  = 3'd0;
	localparam logic [2:0] POL_PRIO  = 3'd1;
	localparam logic [2:0] POL_PPRIO = 3'd2;
	localparam logic [2:0] POL_SRTF  = 3'd3;
	localparam logic [2:0] POL_RR    = 3'd4;
	localparam logic [2:0] POL_SJF   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [15:0] job;
		logic [31:0] arrival;
		logic [15:0] prio;
		logic [31:0] remaining;
		logic [31:0] total;
		logic [31:0] order;
		logic        started;
	} rec_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input transaction
		logic scan_clr;  // start a minimum search
		logic scan_step; // examine one slot
		logic exec;      // apply the command's effect
		logic done;      // present the result
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
	} sts_t;

	function automatic logic [31:0] key_of(input logic [2:0] pol, input rec_t r);
		case (pol)
			POL_PRIO, POL_PPRIO: key_of = {16'd0, r.prio};
			POL_SRTF:            key_of = r.remaining;
			POL_RR:              key_of = r.order;
			POL_SJF:             key_of = r.total;
			default:             key_of = r.arrival;
		endcase
	endfunction

	function automatic logic precedes(input logic [2:0] pol, input rec_t a, input rec_t b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = key_of(pol, a);
		kb = key_of(pol, b);
		if (ka != kb) precedes = ka < kb;
		else if (a.arrival != b.arrival) precedes = a.arrival < b.arrival;
		else precedes = a.order < b.order;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/mpjs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpjs_ctrl: scheduler controller
// Sequences load, slot scan, execution and result handshake.
// ----------------------------------------------------------------------------
module mpjs_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_fire,
	input  wire mpjs_pkg::sts_t sts,
	output mpjs_pkg::ctl_t     ctl,
	output logic               busy,
	output logic               out_valid
);
	import mpjs_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CLR  = 5'b00010,
		S_SCAN = 5'b00100,
		S_EXEC = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_fire) state_d = S_CLR;
			S_CLR:  state_d = S_SCAN;
			S_SCAN: if (sts.scan_last) state_d = S_EXEC;
			S_EXEC: state_d = S_OUT;
			S_OUT:  if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		ctl           = '0;
		ctl.load      = (state_q == S_IDLE) && in_fire;
		ctl.scan_clr  = (state_q == S_CLR);
		ctl.scan_step = (state_q == S_SCAN);
		ctl.exec      = (state_q == S_EXEC);
		ctl.done      = (state_q == S_OUT);
	end

	assign busy      = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule
`default_nettype wire

@@ rtl/core/mpjs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpjs_dp: scheduler datapath
// Job table, running record, serial minimum search and accumulators.
// ----------------------------------------------------------------------------
module mpjs_dp #(
	parameter int QUEUE_DEPTH = mpjs_pkg::QueueDepthDefault
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mpjs_pkg::ctl_t ctl,
	output mpjs_pkg::sts_t     sts,
	input  wire logic [2:0]    policy,
	input  wire logic [1:0]    cmd,
	input  wire logic [15:0]   job_id,
	input  wire logic [31:0]   now,
	input  wire logic [15:0]   prio,
	input  wire logic [31:0]   run_time,
	input  wire logic          has_running,
	output logic               next_valid,
	output logic [15:0]        next_job_id,
	output logic [1:0]         status,
	output logic [31:0]        jobs_seen,
	output logic [47:0]        sum_wait,
	output logic [47:0]        sum_turnaround,
	output logic [47:0]        sum_response
);
	import mpjs_pkg::*;

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Table payload: one register per slot, read through the scan index.
	rec_t              slot_q [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] valid_q;

	rec_t        run_q;
	logic        run_valid_q;
	logic [31:0] order_q, jobs_q, last_q;
	logic        last_set_q;
	logic [47:0] wait_q, ta_q, resp_q;

	logic [1:0]  cmd_q;
	logic [15:0] job_id_q, prio_q;
	logic [31:0] now_q, run_time_q;
	logic        has_run_q;

	logic [IW-1:0] idx_q;
	logic [IW-1:0] best_idx_q, free_idx_q;
	logic          best_ok_q, free_ok_q;
	rec_t          best_q;

	logic        nv_q;
	logic [15:0] nid_q;
	logic [1:0]  st_q;

	rec_t cur;
	assign cur = slot_q[idx_q];
	assign sts.scan_last = (idx_q == IW'(QUEUE_DEPTH - 1));

	logic preempt;
	assign preempt = (policy == POL_PPRIO) || (policy == POL_SRTF) || (policy == POL_RR);

	// Running record charged with elapsed time, RR reordering applied.
	rec_t ev;
	logic [31:0] el;
	always_comb begin
		el = (last_set_q && now_q >= last_q) ? now_q - last_q : 32'd0;
		ev = run_q;
		ev.remaining = (run_q.remaining > el) ? run_q.remaining - el : 32'd0;
		if (policy == POL_RR) ev.order = order_q;
	end

	logic        swap;
	logic        evict;
	rec_t        run_new;
	rec_t        run_go;
	logic [32:0] resp_d, ta_d, wt_d;
	always_comb begin
		evict = has_run_q && run_valid_q;
		swap  = best_ok_q && precedes(policy, best_q, ev);
		if (evict) run_new = (preempt && swap) ? best_q : ev;
		else run_new = best_q;
		// The dispatched record is marked as started.
		run_go         = run_new;
		run_go.started = 1'b1;
		resp_d = {1'b0, now_q} - {1'b0, run_new.arrival};
		ta_d   = {1'b0, now_q} - {1'b0, run_q.arrival};
		wt_d   = ta_d - {1'b0, run_q.total};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= cmd;
			job_id_q   <= job_id;
			now_q      <= now;
			prio_q     <= prio;
			run_time_q <= run_time;
			has_run_q  <= has_running;
		end
		if (ctl.scan_step && valid_q[idx_q] &&
		    (!best_ok_q || precedes(policy, cur, best_q))) begin
			best_q     <= cur;
			best_idx_q <= idx_q;
		end
		if (ctl.exec) begin
			case (cmd_t'(cmd_q))
				CMD_NEW: if (free_ok_q) begin
					slot_q[free_idx_q] <= '{job: job_id_q, arrival: now_q, prio: prio_q,
						remaining: run_time_q, total: run_time_q, order: order_q,
						started: 1'b0};
				end
				CMD_EXPIRE: if (evict && preempt && swap) slot_q[best_idx_q] <= ev;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			run_q       <= '0;
			run_valid_q <= 1'b0;
			order_q     <= '0;
			jobs_q      <= '0;
			last_q      <= '0;
			last_set_q  <= 1'b0;
			wait_q      <= '0;
			ta_q        <= '0;
			resp_q      <= '0;
			idx_q       <= '0;
			best_ok_q   <= 1'b0;
			free_ok_q   <= 1'b0;
			free_idx_q  <= '0;
			nv_q        <= 1'b0;
			nid_q       <= '0;
			st_q        <= ST_OK;
		end else begin
			if (ctl.scan_clr) begin
				idx_q     <= '0;
				best_ok_q <= 1'b0;
				free_ok_q <= 1'b0;
			end
			if (ctl.scan_step) begin
				if (!sts.scan_last) idx_q <= idx_q + 1'b1;
				if (valid_q[idx_q]) best_ok_q <= 1'b1;
				if (!valid_q[idx_q] && !free_ok_q) begin
					free_ok_q  <= 1'b1;
					free_idx_q <= idx_q;
				end
			end
			if (ctl.exec) begin
				nv_q  <= 1'b0;
				nid_q <= '0;
				st_q  <= ST_OK;
				case (cmd_t'(cmd_q))
					CMD_NEW: begin
						if (!free_ok_q) st_q <= ST_FULL;
						else begin
							valid_q[free_idx_q] <= 1'b1;
							order_q <= order_q + 1'b1;
							jobs_q  <= jobs_q + 1'b1;
							if (!last_set_q) begin
								last_q     <= now_q;
								last_set_q <= 1'b1;
							end
						end
					end
					CMD_EXPIRE: begin
						last_q     <= now_q;
						last_set_q <= 1'b1;
						if (evict) begin
							if (preempt && policy == POL_RR) order_q <= order_q + 1'b1;
							run_q <= preempt ? run_go : run_new;
							if (preempt && !run_new.started && !resp_d[32])
								resp_q <= resp_q + {16'd0, resp_d[31:0]};
							nv_q  <= 1'b1;
							nid_q <= run_new.job;
						end else if (!best_ok_q) begin
							run_valid_q <= 1'b0;
							st_q        <= ST_EMPTY;
						end else begin
							valid_q[best_idx_q] <= 1'b0;
							run_q         <= run_go;
							run_valid_q   <= 1'b1;
							if (!run_new.started && !resp_d[32])
								resp_q <= resp_q + {16'd0, resp_d[31:0]};
							nv_q  <= 1'b1;
							nid_q <= run_new.job;
						end
					end
					CMD_FINISH: if (run_valid_q) begin
						if (!wt_d[32] && !ta_d[32]) wait_q <= wait_q + {16'd0, wt_d[31:0]};
						if (!ta_d[32]) ta_q <= ta_q + {16'd0, ta_d[31:0]};
						run_valid_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	assign next_valid     = nv_q;
	assign next_job_id    = nid_q;
	assign status         = st_q;
	assign jobs_seen      = jobs_q;
	assign sum_wait       = wait_q;
	assign sum_turnaround = ta_q;
	assign sum_response   = resp_q;
endmodule
`default_nettype wire

@@ rtl/core/multi_policy_job_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler: six-policy job scheduler
// Job table with serial best-job search, one running record and time totals.
// ----------------------------------------------------------------------------
// Each input transaction is captured on acceptance, then the minimum search is
// cleared, examines one table slot per cycle and the command is applied; the
// result is held until the master side takes it, and only then is a new
// transaction accepted, so items never overlap inside the block.
// The user must write the policy through the cfg channel only while the block
// is idle; the block itself does not enforce it. The totals wrap at 48 bits;
// software divides them by jobs_seen for averages.
module multi_policy_job_scheduler #(
	parameter int QUEUE_DEPTH = mpjs_pkg::QueueDepthDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: cmd[1:0], job_id[17:2], now[49:18], prio[65:50], run_time[97:66],
	// has_running[98], zero fill to 104 bits
	input  wire logic [103:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: next_valid[0], next_job_id[16:1], status[18:17], jobs_seen[50:19],
	// sum_wait[98:51], sum_turnaround[146:99], sum_response[194:147], zero fill to 200
	output logic [199:0]     m_tdata
);
	import mpjs_pkg::*;

	logic [2:0] policy_q;
	ctl_t ctl;
	sts_t sts;
	logic busy;
	logic in_fire, out_fire;

	logic        next_valid;
	logic [15:0] next_job_id;
	logic [1:0]  status;
	logic [31:0] jobs_seen;
	logic [47:0] sum_wait, sum_turnaround, sum_response;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) policy_q <= POL_FCFS;
		else if (cfg_valid) policy_q <= cfg_data;
	end

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	mpjs_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire, .sts, .ctl, .busy,
		.out_valid(m_tvalid)
	);

	mpjs_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk, .arst_n, .ctl, .sts,
		.policy(policy_q),
		.cmd(s_tdata[1:0]),
		.job_id(s_tdata[17:2]),
		.now(s_tdata[49:18]),
		.prio(s_tdata[65:50]),
		.run_time(s_tdata[97:66]),
		.has_running(s_tdata[98]),
		.next_valid, .next_job_id, .status, .jobs_seen,
		.sum_wait, .sum_turnaround, .sum_response
	);

	assign m_tdata = {5'd0, sum_response, sum_turnaround, sum_wait, jobs_seen,
		status, next_job_id, next_valid};

`ifndef ASSERT_OFF
	// A result never appears in the same cycle as an accepted transaction.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && m_tvalid)) else $error("input accepted while result pending");
	// A dispatch always reports status ok.
	a_dispatch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && next_valid |-> status == ST_OK) else $error("dispatch with bad status");
	// jobs_seen only moves while the block is busy.
	a_jobs_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !in_fire |=> $stable(jobs_seen)) else $error("job count moved while idle");
`endif
endmodule
`default_nettype wire

@@ tb/tb_multi_policy_job_scheduler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_multi_policy_job_scheduler: self-checking bench for the job scheduler
// Drives job commands under every policy, predicts each result and compares.
// ----------------------------------------------------------------------------
module tb_multi_policy_job_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	import mpjs_pkg::*;

	localparam int Depth = 16;

	// Decoded form of one result transaction.
	typedef struct packed {
		logic        dispatched;
		logic [15:0] job;
		logic [1:0]  status;
		logic [31:0] jobs;
		logic [47:0] wait_sum;
		logic [47:0] ta_sum;
		logic [47:0] resp_sum;
	} sched_result_t;

	// Scoreboard: holds its own copy of the scheduler state and the queue of
	// results that are still owed by the block.
	class sched_scoreboard;
		logic [2:0]    pol;
		logic          tbl_valid [Depth];
		rec_t          tbl [Depth];
		logic          busy;
		rec_t          cur;
		logic [31:0]   seq_no;
		logic [31:0]   jobs;
		logic [31:0]   stamp;
		logic          stamp_set;
		logic [47:0]   wait_sum;
		logic [47:0]   ta_sum;
		logic [47:0]   resp_sum;
		sched_result_t owed [$];
		int            errors;
		int            checked;

		function void clear();
			pol = POL_FCFS;
			foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
			busy = 1'b0;
			cur = '0;
			seq_no = 0;
			jobs = 0;
			stamp = 0;
			stamp_set = 1'b0;
			wait_sum = 0;
			ta_sum = 0;
			resp_sum = 0;
			owed.delete();
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] sort_key(rec_t r);
			case (pol)
				POL_PRIO, POL_PPRIO: return {16'd0, r.prio};
				POL_SRTF:            return r.remaining;
				POL_RR:              return r.order;
				POL_SJF:             return r.total;
				default:             return r.arrival;
			endcase
		endfunction

		function logic wins(rec_t a, rec_t b);
			logic [31:0] ka;
			logic [31:0] kb;
			ka = sort_key(a);
			kb = sort_key(b);
			if (ka != kb) return ka < kb;
			if (a.arrival != b.arrival) return a.arrival < b.arrival;
			return a.order < b.order;
		endfunction

		function int pick_best();
			int best;
			best = -1;
			for (int i = 0; i < Depth; i++)
				if (tbl_valid[i] && (best < 0 || wins(tbl[i], tbl[best]))) best = i;
			return best;
		endfunction

		// Adds the response time on the first dispatch of a job.
		function void mark_started(ref rec_t r, input logic [31:0] t);
			if (!r.started) begin
				if (t > r.arrival) resp_sum = resp_sum + 48'(t - r.arrival);
				r.started = 1'b1;
			end
		endfunction

		function int table_used();
			int n;
			n = 0;
			foreach (tbl_valid[i]) n += tbl_valid[i];
			return n;
		endfunction

		function void note_input(logic [103:0] d);
			cmd_t          c;
			logic [31:0]   t;
			logic [31:0]   el;
			logic          preempt;
			int            slot;
			int            b;
			rec_t          ev;
			rec_t          run;
			sched_result_t res;
			logic [32:0]   ta;
			c = cmd_t'(d[1:0]);
			t = d[49:18];
			res = '{1'b0, 16'd0, ST_OK, 32'd0, 48'd0, 48'd0, 48'd0};
			preempt = (pol == POL_PPRIO || pol == POL_SRTF || pol == POL_RR);
			case (c)
				CMD_NEW: begin
					slot = -1;
					for (int i = Depth - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
					if (slot < 0) res.status = ST_FULL;
					else begin
						tbl[slot] = '{job: d[17:2], arrival: t, prio: d[65:50],
							remaining: d[97:66], total: d[97:66], order: seq_no,
							started: 1'b0};
						tbl_valid[slot] = 1'b1;
						seq_no++;
						jobs++;
						if (!stamp_set) begin
							stamp = t;
							stamp_set = 1'b1;
						end
					end
				end
				CMD_EXPIRE: begin
					if (d[98] && busy) begin
						ev = cur;
						el = (!stamp_set || t < stamp) ? 32'd0 : t - stamp;
						ev.remaining = (ev.remaining > el) ? ev.remaining - el : 32'd0;
						run = ev;
						if (preempt) begin
							if (pol == POL_RR) begin
								ev.order = seq_no;
								seq_no++;
							end
							run = ev;
							b = pick_best();
							if (b >= 0 && wins(tbl[b], ev)) begin
								run = tbl[b];
								tbl[b] = ev;
							end
							mark_started(run, t);
						end
						cur = run;
						busy = 1'b1;
						res.dispatched = 1'b1;
						res.job = run.job;
					end else begin
						b = pick_best();
						if (b < 0) begin
							busy = 1'b0;
							res.status = ST_EMPTY;
						end else begin
							run = tbl[b];
							tbl_valid[b] = 1'b0;
							mark_started(run, t);
							cur = run;
							busy = 1'b1;
							res.dispatched = 1'b1;
							res.job = run.job;
						end
					end
					stamp = t;
					stamp_set = 1'b1;
				end
				CMD_FINISH: begin
					if (busy) begin
						if (t > cur.arrival) begin
							ta = {1'b0, t - cur.arrival};
							ta_sum = ta_sum + 48'(ta);
							if (ta > {1'b0, cur.total})
								wait_sum = wait_sum + 48'(ta - {1'b0, cur.total});
						end
						busy = 1'b0;
					end
				end
				default: ;
			endcase
			res.jobs = jobs;
			res.wait_sum = wait_sum;
			res.ta_sum = ta_sum;
			res.resp_sum = resp_sum;
			owed.push_back(res);
		endfunction

		function void check_result(logic [199:0] d);
			sched_result_t e;
			sched_result_t a;
			a = '{d[0], d[16:1], d[18:17], d[50:19], d[98:51], d[146:99], d[194:147]};
			checked++;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: unexpected result transaction %h", d);
				return;
			end
			e = owed.pop_front();
			if (a != e || d[199:195] != 0) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: result %0d mismatch", checked);
					$display("  expected nv=%0d id=%h st=%0d jobs=%0d w=%0d ta=%0d r=%0d",
						e.dispatched, e.job, e.status, e.jobs, e.wait_sum, e.ta_sum,
						e.resp_sum);
					$display("  actual   nv=%0d id=%h st=%0d jobs=%0d w=%0d ta=%0d r=%0d",
						a.dispatched, a.job, a.status, a.jobs, a.wait_sum, a.ta_sum,
						a.resp_sum);
				end
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [199:0] m_tdata;

	multi_policy_job_scheduler #(.QUEUE_DEPTH(Depth)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	sched_scoreboard sb;
	int send_idle_pct;   // chance in a hundred that the sender idles a cycle
	int recv_stall_pct;  // chance in a hundred that the receiver stalls a cycle
	logic [31:0] clock_now;  // job time base, moves forward mostly
	int sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A generous fixed limit: the random phases send roughly 950 items in all,
	// with long stalls on both sides.
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	// The receiver side: tready is randomised at each falling edge and every
	// result transaction is checked at the rising edge at which it is taken.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Sends one transaction, with random idle cycles before it. The model is
	// updated at the edge of acceptance so that the expectation is ready well
	// before the result arrives. The block is never ready in the cycle after
	// an acceptance, so the first falling edge here costs no throughput.
	task automatic send_job_cmd(cmd_t c, logic [15:0] id, logic [31:0] t,
			logic [15:0] p, logic [31:0] rt, logic hr);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		s_tdata <= {5'd0, hr, rt, p, t, id, c};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(s_tdata);
		sent++;
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.owed.size() != 0) @(negedge clk);
		repeat (Depth + 8) @(negedge clk);
	endtask

	task automatic set_policy(logic [2:0] p);
		wait_drained();
		cfg_data <= p;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.pol = p;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly small steps in time; now and then a backward or huge jump.
	function automatic logic [31:0] next_time();
		case ($urandom_range(19))
			0: return $urandom;
			1: return clock_now - $urandom_range(50);
			default: begin
				clock_now = clock_now + $urandom_range(40);
				return clock_now;
			end
		endcase
	endfunction

	// Random item, weighted so that the table fills and drains and jobs run,
	// get preempted and finish. Full-range fields appear now and then.
	task automatic send_random_item();
		int          r;
		logic [15:0] p;
		logic [31:0] rt;
		r = $urandom_range(99);
		p = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
		rt = ($urandom_range(7) == 0) ? $urandom : 32'($urandom_range(1, 60));
		if (r < 40 + (sb.table_used() < 4 ? 20 : 0))
			send_job_cmd(CMD_NEW, 16'($urandom), next_time(), p, rt, 1'($urandom));
		else if (r < 78)
			send_job_cmd(CMD_EXPIRE, 16'($urandom), next_time(), p, rt,
				($urandom_range(9) != 0));
		else if (r < 97)
			send_job_cmd(CMD_FINISH, 16'($urandom), next_time(), p, rt, 1'($urandom));
		else
			send_job_cmd(CMD_NONE, 16'($urandom), $urandom, 16'($urandom), $urandom,
				1'($urandom));
	endtask

	initial begin
		int per_phase;
		logic [2:0] pol_seq [8];
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		clock_now = 100;
		sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part. Idle expiry on an empty table, finish while idle and
		// the spare command come first, then extreme field values.
		send_job_cmd(CMD_EXPIRE, 16'd0, 32'd10, 16'd0, 32'd0, 1'b1);
		send_job_cmd(CMD_FINISH, 16'd0, 32'd12, 16'd0, 32'd0, 1'b0);
		send_job_cmd(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		send_job_cmd(CMD_NEW, 16'hFFFF, 32'hFFFF_FFF0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
		send_job_cmd(CMD_NEW, 16'h0000, 32'd0, 16'h0000, 32'd0, 1'b1);
		send_job_cmd(CMD_EXPIRE, 16'd0, 32'd5, 16'd0, 32'd0, 1'b0);
		// Elapsed time goes negative, so nothing is charged.
		send_job_cmd(CMD_EXPIRE, 16'd0, 32'd2, 16'd0, 32'd0, 1'b1);
		send_job_cmd(CMD_FINISH, 16'd0, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0);
		send_job_cmd(CMD_EXPIRE, 16'd0, 32'd3, 16'd0, 32'd0, 1'b1);
		// Finish earlier than arrival: negative terms count as zero.
		send_job_cmd(CMD_FINISH, 16'd0, 32'd4, 16'd0, 32'd0, 1'b0);
		// Fill the table past its depth so that two jobs are dropped.
		for (int i = 0; i < Depth + 2; i++)
			send_job_cmd(CMD_NEW, 16'(i + 1), 32'd50, 16'(i % 3), 32'(i % 4), 1'b0);
		// Dispatch a job, then expire with has_running clear: the old record is dropped.
		send_job_cmd(CMD_EXPIRE, 16'd0, 32'd60, 16'd0, 32'd0, 1'b1);
		send_job_cmd(CMD_EXPIRE, 16'd0, 32'd61, 16'd0, 32'd0, 1'b0);

		// Random phases over all policies, the unused codes among them, with
		// the idling patterns taking turns.
		pol_seq = '{POL_FCFS, POL_PRIO, POL_PPRIO, POL_SRTF, POL_RR, POL_SJF,
			3'd7, 3'd6};
		per_phase = 950 / 16;
		for (int ph = 0; ph < 16; ph++) begin
			set_policy(pol_seq[ph % 8]);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			for (int k = 0; k < per_phase; k++) begin
				send_random_item();
				// Hold off until the block has returned everything owed.
				if (k == per_phase / 2) while (sb.owed.size() != 0) @(negedge clk);
			end
		end
		set_policy(POL_FCFS);

		recv_stall_pct = 0;
		wait_drained();
		$display("Covered %0d transactions over all policy codes, %0d results checked.",
			sent, sb.checked);
		$display("Included full table, empty expiry, idle finish and time wrap cases.");
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
